FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/pds_pkg.sv
// ----------------------------------------------------------------------------
// Positional deque store package
// Opcodes, status codes, field widths and shared types of the store.
// ----------------------------------------------------------------------------
package pds_pkg;

   localparam int PDS_CAPACITY = 16;

   localparam int OPCODE_W = 4;
   localparam int VALUE_W = 32;
   localparam int POS_W = 8;
   localparam int LEN_W = 5;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK = 4'd1,
      OP_POP_FRONT = 4'd2,
      OP_POP_BACK = 4'd3,
      OP_INSERT_AT = 4'd4,
      OP_REMOVE_AT = 4'd5,
      OP_READ_AT = 4'd6,
      OP_READ_FRONT = 4'd7,
      OP_READ_BACK = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic is_op;
   } entry_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

FILE: sv/pds_ctrl.sv
// ----------------------------------------------------------------------------
// Positional deque store controller
// Sequences capture and execution of one request and owns the result valid.
// ----------------------------------------------------------------------------
module pds_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output pds_pkg::cmd_type cmd
);
   import pds_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic valid_ff;
   logic valid_in;
   logic can_go;

   assign can_go = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_tvalid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (can_go) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         CTL_EXEC: begin
            cmd.exec = can_go;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.exec) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

FILE: sv/pds_dpath.sv
// ----------------------------------------------------------------------------
// Positional deque store datapath
// Request registers, the shifting row of entry cells and the result register.
// ----------------------------------------------------------------------------
module pds_dpath #(
   parameter int CAPACITY = pds_pkg::PDS_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  pds_pkg::cmd_type cmd,
   input  logic [pds_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [pds_pkg::VALUE_W-1:0] req_entry_value,
   input  logic req_entry_is_operator,
   input  logic [pds_pkg::POS_W-1:0] req_position,
   output logic [pds_pkg::VALUE_W-1:0] rsp_result_value,
   output logic rsp_result_is_operator,
   output logic [pds_pkg::LEN_W-1:0] rsp_list_length,
   output logic [pds_pkg::STATUS_W-1:0] rsp_status
);
   import pds_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   op_type op_ff;
   entry_type new_ff;
   logic [POS_W-1:0] pos_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   entry_type cells_ff [CAPACITY];
   entry_type cells_in [CAPACITY];
   entry_type res_ff;
   entry_type res_in;
   logic [LEN_W-1:0] len_ff;
   status_type st_ff;
   status_type st_in;

   logic full;
   logic empty;
   logic posok;
   logic do_ins;
   logic do_del;
   logic [IW-1:0] idx;
   logic [IW-1:0] pos_idx;
   logic [IW-1:0] back_idx;
   logic [IW-1:0] end_idx;
   entry_type rd_entry;

   assign full = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);
   assign posok = (pos_ff != '0) && (PW'(pos_ff) <= PW'(count_ff));
   assign pos_idx = IW'(pos_ff - POS_W'(1));
   assign back_idx = IW'(count_ff - CW'(1));
   assign end_idx = IW'(count_ff);
   assign rd_entry = cells_ff[idx];

   always_comb begin
      st_in = ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      idx = '0;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               st_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx = (op_ff == OP_PUSH_FRONT) ? '0 : end_idx;
            end
         end
         OP_POP_FRONT, OP_READ_FRONT: begin
            if (empty) begin
               st_in = ST_EMPTY;
            end else begin
               do_del = (op_ff == OP_POP_FRONT);
            end
         end
         OP_POP_BACK, OP_READ_BACK: begin
            if (empty) begin
               st_in = ST_EMPTY;
            end else begin
               idx = back_idx;
               do_del = (op_ff == OP_POP_BACK);
            end
         end
         OP_INSERT_AT: begin
            if (!posok) begin
               st_in = ST_BADPOS;
            end else if (full) begin
               st_in = ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx = pos_idx;
            end
         end
         OP_REMOVE_AT, OP_READ_AT: begin
            if (!posok) begin
               st_in = ST_BADPOS;
            end else begin
               idx = pos_idx;
               do_del = (op_ff == OP_REMOVE_AT);
            end
         end
         default: begin
            st_in = ST_BADPOS;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_ins) begin
            if (i == int'(idx)) begin
               cells_in[i] = new_ff;
            end else if (i != 0 && i > int'(idx)) begin
               cells_in[i] = cells_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (do_del) begin
            if (i != CAPACITY - 1 && i >= int'(idx)) begin
               cells_in[i] = cells_ff[(i == CAPACITY - 1) ? i : i + 1];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      if (st_in != ST_OK) begin
         res_in.value = '1;
         res_in.is_op = 1'b0;
      end else if (do_ins) begin
         res_in = new_ff;
      end else begin
         res_in = rd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_opcode);
         new_ff.value <= req_entry_value;
         new_ff.is_op <= req_entry_is_operator;
         pos_ff <= req_position;
      end
      if (cmd.exec) begin
         cells_ff <= cells_in;
         res_ff <= res_in;
         len_ff <= LEN_W'(count_in);
         st_ff <= st_in;
      end
   end

   assign rsp_result_value = res_ff.value;
   assign rsp_result_is_operator = res_ff.is_op;
   assign rsp_list_length = len_ff;
   assign rsp_status = st_ff;

endmodule

FILE: sv/positional_deque_store.sv
// ----------------------------------------------------------------------------
// Positional deque store
// Bounded ordered list with push, pop, insert, remove and read by position.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat contents
// req      in         tdata: opcode, entry_value, position; tuser: is_operator
// rsp      out        tdata: result_value, list_length, status; tuser: is_operator
//
// Each request is first captured from its beat and then applied to the row of
// entry cells; an insert or removal shifts the cells from its position on by one place.
// A new request is taken only after the previous one has been applied.
// A stalled result holds the execute step of the next request until taken.
// Reset is synchronous and empties the list at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module positional_deque_store #(
   parameter int CAPACITY = pds_pkg::PDS_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // opcode[3:0], entry_value[35:4], position[43:36], zero pad[47:44]
   input  logic [pds_pkg::REQ_TDATA_W-1:0] req_tdata,
   // entry_is_operator[0]
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_value[31:0], list_length[36:32], status[38:37], zero pad[39]
   output logic [pds_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_is_operator[0]
   output logic rsp_tuser
);
   import pds_pkg::*;

   cmd_type cmd;
   logic [VALUE_W-1:0] result_value;
   logic [LEN_W-1:0] list_length;
   logic [STATUS_W-1:0] status;

   pds_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd(cmd)
   );

   pds_dpath #(
      .CAPACITY(CAPACITY)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_opcode(req_tdata[3:0]),
      .req_entry_value(req_tdata[35:4]),
      .req_entry_is_operator(req_tuser),
      .req_position(req_tdata[43:36]),
      .rsp_result_value(result_value),
      .rsp_result_is_operator(rsp_tuser),
      .rsp_list_length(list_length),
      .rsp_status(status)
   );

   assign rsp_tdata = {1'b0, status, list_length, result_value};

endmodule

FILE: sv/pds_checker.sv
// ----------------------------------------------------------------------------
// Positional deque store checker
// Port-level assertions on results of the store, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pds_checker #(
   parameter int CAPACITY = pds_pkg::PDS_CAPACITY
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [pds_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic rsp_tuser
);
   import pds_pkg::*;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

   logic [STATUS_W-1:0] st;
   logic [LEN_W-1:0] len;
   logic [VALUE_W-1:0] res_val;
   logic rsp_stall;
   logic [RSP_TDATA_W:0] rsp_beat;

   assign st = rsp_tdata[38:37];
   assign len = rsp_tdata[36:32];
   assign res_val = rsp_tdata[31:0];
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat = {rsp_tuser, rsp_tdata};

   `ASSERT_IMPLY(a_empty_len, clock, reset, rsp_tvalid && st == ST_EMPTY, len == '0)
   `ASSERT_IMPLY(a_full_len, clock, reset, rsp_tvalid && st == ST_FULL, len == FULL_LEN)
   `ASSERT_IMPLY(a_err_res, clock, reset, rsp_tvalid && st != ST_OK, res_val == '1 && !rsp_tuser)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_beat))
   `ASSERT_NEXT(a_req_gap, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind positional_deque_store pds_checker #(.CAPACITY(CAPACITY)) u_pds_checker (.*);

FILE: sim/tb_positional_deque_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional deque store testbench
// Sends push, pop, insert, remove and read requests, with random gaps on the
// request side and random stalls on the result side. Each beat taken by the
// store is applied to a list kept here, and every result beat is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_positional_deque_store;
   import pds_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED_LOW = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HIGH = 4'd15;
   localparam int RANDOM_ITEMS = 1875;
   localparam int MAX_WAIT = 13;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0] value;
      logic is_op;
      logic [POS_W-1:0] position;
      int gap;
      bit hold;
   } list_request_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic is_op;
      logic [LEN_W-1:0] length;
      status_type status;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   list_request_type request_queue[$];
   list_result_type pending_results[$];
   entry_type stored_entries[$];
   int planned_len = 0;
   bit sender_steady = 1'b0;
   int fail_count = 0;

   list_request_type current_req;
   bit have_current = 1'b0;
   bit drive_valid;
   int gap_left = 0;

   bit take_ready;
   bit rsp_steady = 1'b0;
   int stall_left = 0;
   int results_seen = 0;
   list_result_type wanted;

   positional_deque_store i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void apply_list_op(input list_request_type rq);
      list_result_type outcome;
      entry_type ent;
      int idx;
      bit pos_ok;
      outcome.value = '1;
      outcome.is_op = 1'b0;
      outcome.status = ST_OK;
      ent.value = rq.value;
      ent.is_op = rq.is_op;
      pos_ok = rq.position >= 1 && rq.position <= stored_entries.size();
      case (rq.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (stored_entries.size() >= PDS_CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               if (rq.opcode == OP_PUSH_FRONT) stored_entries.push_front(ent);
               else stored_entries.push_back(ent);
               outcome.value = ent.value;
               outcome.is_op = ent.is_op;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
            if (stored_entries.size() == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               idx = (rq.opcode == OP_POP_FRONT || rq.opcode == OP_READ_FRONT) ?
                     0 : stored_entries.size() - 1;
               outcome.value = stored_entries[idx].value;
               outcome.is_op = stored_entries[idx].is_op;
               if (rq.opcode == OP_POP_FRONT || rq.opcode == OP_POP_BACK)
                  stored_entries.delete(idx);
            end
         end
         OP_INSERT_AT: begin
            if (!pos_ok) begin
               outcome.status = ST_BADPOS;
            end else if (stored_entries.size() >= PDS_CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               stored_entries.insert(rq.position - 1, ent);
               outcome.value = ent.value;
               outcome.is_op = ent.is_op;
            end
         end
         OP_REMOVE_AT, OP_READ_AT: begin
            if (!pos_ok) begin
               outcome.status = ST_BADPOS;
            end else begin
               idx = rq.position - 1;
               outcome.value = stored_entries[idx].value;
               outcome.is_op = stored_entries[idx].is_op;
               if (rq.opcode == OP_REMOVE_AT) stored_entries.delete(idx);
            end
         end
         default: begin
            outcome.status = ST_BADPOS;
         end
      endcase
      outcome.length = LEN_W'(stored_entries.size());
      pending_results.push_back(outcome);
   endfunction

   task automatic add_req(input logic [OPCODE_W-1:0] opcode, input logic [VALUE_W-1:0] value,
                          input logic is_op, input logic [POS_W-1:0] position, input bit hold);
      list_request_type rq;
      rq.opcode = opcode;
      rq.value = value;
      rq.is_op = is_op;
      rq.position = position;
      rq.gap = sender_steady ? 0 : $urandom_range(0, MAX_WAIT);
      rq.hold = hold;
      request_queue.push_back(rq);
      case (opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (planned_len < PDS_CAPACITY) planned_len++;
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (planned_len > 0) planned_len--;
         end
         OP_INSERT_AT: begin
            if (position >= 1 && position <= planned_len && planned_len < PDS_CAPACITY)
               planned_len++;
         end
         OP_REMOVE_AT: begin
            if (position >= 1 && position <= planned_len) planned_len--;
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [OPCODE_W-1:0] pick_opcode(input mix_type mix);
      int r;
      int push_cut;
      int insert_cut;
      int pop_cut;
      int remove_cut;
      r = $urandom_range(0, 99);
      if (r < 3) return OPCODE_W'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH));
      if (mix == MIX_EVEN) return OPCODE_W'($urandom_range(OP_PUSH_FRONT, OP_READ_BACK));
      push_cut = (mix == MIX_FILL) ? 40 : 15;
      insert_cut = (mix == MIX_FILL) ? 65 : 25;
      pop_cut = (mix == MIX_FILL) ? 75 : 55;
      remove_cut = (mix == MIX_FILL) ? 82 : 80;
      if (r < push_cut) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < insert_cut) return OP_INSERT_AT;
      if (r < pop_cut) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      if (r < remove_cut) return OP_REMOVE_AT;
      case ($urandom_range(0, 2))
         0: return OP_READ_AT;
         1: return OP_READ_FRONT;
         default: return OP_READ_BACK;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7 && planned_len > 0) return POS_W'($urandom_range(1, planned_len));
      if (r == 7) return POS_W'(planned_len + 1);
      if (r == 8) return '0;
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Request driver. A held request waits until every result is back.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         have_current = 1'b0;
      end else begin
         drive_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_list_op(current_req);
            drive_valid = 1'b0;
            have_current = 1'b0;
         end
         if (!have_current && request_queue.size() > 0) begin
            current_req = request_queue.pop_front();
            have_current = 1'b1;
            gap_left = current_req.gap;
         end
         if (have_current && !drive_valid) begin
            if (!(current_req.hold && pending_results.size() > 0)) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  drive_valid = 1'b1;
                  req_tdata <= {4'b0, current_req.position, current_req.value,
                                current_req.opcode};
                  req_tuser <= current_req.is_op;
               end
            end
         end
         req_tvalid <= drive_valid;
      end
   end

   // Result monitor with random stalls after each beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         take_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               wanted = pending_results.pop_front();
               if (rsp_tdata[31:0] !== wanted.value) begin
                  $error("result_value expected %0d got %0d",
                         $signed(wanted.value), $signed(rsp_tdata[31:0]));
                  fail_count++;
               end
               if (rsp_tuser !== wanted.is_op) begin
                  $error("result_is_operator expected %0d got %0d", wanted.is_op, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[36:32] !== wanted.length) begin
                  $error("list_length expected %0d got %0d", wanted.length, rsp_tdata[36:32]);
                  fail_count++;
               end
               if (rsp_tdata[38:37] !== wanted.status) begin
                  $error("status expected %0d got %0d", wanted.status, rsp_tdata[38:37]);
                  fail_count++;
               end
            end
            results_seen++;
            if (results_seen % 150 == 0) rsp_steady = ($urandom_range(0, 3) == 0);
            stall_left = rsp_steady ? 0 : $urandom_range(0, MAX_WAIT);
            take_ready = (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left > 0) stall_left--;
            take_ready = (stall_left == 0);
         end
         rsp_tready <= take_ready;
      end
   end

   initial begin
      int random_count;
      int seg_len;
      mix_type mix;
      logic [OPCODE_W-1:0] opcode;
      random_count = 0;

      // Empty list: every read, pop, remove and insert must fail.
      add_req(OP_POP_FRONT, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_POP_BACK, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_READ_FRONT, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_READ_BACK, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_READ_AT, '0, 1'b0, 8'd1, 1'b0);
      add_req(OP_REMOVE_AT, '0, 1'b0, 8'd1, 1'b0);
      add_req(OP_INSERT_AT, 32'h1234_5678, 1'b1, 8'd1, 1'b0);
      add_req(OP_UNUSED_LOW, '1, 1'b1, 8'd255, 1'b0);
      add_req(OP_UNUSED_HIGH, '1, 1'b1, 8'd1, 1'b0);
      // Build a short list from the value extremes.
      add_req(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, 8'd0, 1'b0);
      add_req(OP_PUSH_BACK, 32'h8000_0000, 1'b0, 8'd0, 1'b0);
      add_req(OP_INSERT_AT, '0, 1'b1, 8'd1, 1'b0);
      add_req(OP_INSERT_AT, '1, 1'b0, 8'd3, 1'b0);
      add_req(OP_INSERT_AT, 32'h5555_5555, 1'b1, 8'd5, 1'b0);
      add_req(OP_INSERT_AT, 32'hAAAA_AAAA, 1'b1, 8'd0, 1'b0);
      add_req(OP_READ_AT, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_READ_AT, '0, 1'b0, 8'd4, 1'b0);
      add_req(OP_READ_AT, '0, 1'b0, 8'd5, 1'b0);
      add_req(OP_READ_AT, '0, 1'b0, 8'd255, 1'b0);
      add_req(OP_READ_FRONT, '0, 1'b0, 8'd0, 1'b0);
      add_req(OP_READ_BACK, '0, 1'b0, 8'd0, 1'b0);
      // Removal at the first position, then twice at the last, then at position zero.
      add_req(OP_REMOVE_AT, '0, 1'b0, 8'd1, 1'b0);
      add_req(OP_REMOVE_AT, '0, 1'b0, 8'd3, 1'b0);
      add_req(OP_REMOVE_AT, '0, 1'b0, 8'd2, 1'b0);
      add_req(OP_REMOVE_AT, '0, 1'b0, 8'd0, 1'b0);

      // Random segments that lean toward filling, draining or neither.
      while (random_count < RANDOM_ITEMS) begin
         mix = mix_type'($urandom_range(MIX_FILL, MIX_EVEN));
         sender_steady = ($urandom_range(0, 3) == 0);
         seg_len = $urandom_range(40, 160);
         for (int k = 0; k < seg_len && random_count < RANDOM_ITEMS; k++) begin
            opcode = pick_opcode(mix);
            add_req(opcode, pick_value(), 1'($urandom_range(0, 1)), pick_position(), k == 0);
            random_count++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (request_queue.size() > 0 || have_current || pending_results.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
